@@ design/bmw_pkg.sv @@
package bmw_pkg;

  // Geometry of the 7x7 kernel and window.
  localparam int KSTRIDE     = 7;
  localparam int WINDOW_BITS = KSTRIDE * KSTRIDE;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_RADIUS = 3;
  localparam int DEFAULT_MAX_WIDTH  = 1024;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = WINDOW_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 3'd4;

  // Register field widths.
  localparam int MODE_BITS   = 2;
  localparam int RADIUS_BITS = 2;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_BITS    = 12;

  localparam int HEIGHT_LIMIT = 4096;

  // Operating modes.
  localparam logic [MODE_BITS-1:0] MODE_BORDER   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXPAND   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CONTRACT = 2'd2;

  // Reset values of the registers.
  localparam logic [MODE_BITS-1:0]   RESET_MODE   = MODE_EXPAND;
  localparam logic [RADIUS_BITS-1:0] RESET_RADIUS = 2'd1;
  localparam logic [WINDOW_BITS-1:0] RESET_KERNEL = '1;
  localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 13'd1024;

  // Neighbour counting.
  localparam int COUNT_BITS  = 3;
  localparam int SUM_BITS    = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [RADIUS_BITS-1:0] radius;
    logic [WINDOW_BITS-1:0] kernel_mask;
    logic [WIDTH_BITS-1:0]  frame_width;
    logic [HEIGHT_BITS-1:0] frame_height;
  } cfg_t;

  // Radius saturated to what the line store can hold.
  function automatic logic [RADIUS_BITS-1:0] eff_radius(logic [RADIUS_BITS-1:0] radius,
                                                        int max_radius);
    logic [RADIUS_BITS-1:0] limit;
    limit = RADIUS_BITS'(max_radius);
    return (radius > limit) ? limit : radius;
  endfunction

  // Kernel remapped into window coordinates: bit 7c+k is column age c, row age k.
  // Cells outside the window side and the centre cell are cleared.
  function automatic logic [WINDOW_BITS-1:0] window_mask(logic [WINDOW_BITS-1:0] kernel,
                                                         logic [RADIUS_BITS-1:0] r);
    logic [WINDOW_BITS-1:0] m;
    int span;
    int rc;
    m    = '0;
    span = 2 * int'(r);
    rc   = int'(r);
    for (int c = 0; c < KSTRIDE; c++) begin
      for (int k = 0; k < KSTRIDE; k++) begin
        if (c <= span && k <= span && !(c == rc && k == rc)) begin
          m[c*KSTRIDE + k] = kernel[(span - k)*KSTRIDE + (span - c)];
        end
      end
    end
    return m;
  endfunction

  function automatic logic [COUNT_BITS-1:0] popcount7(logic [KSTRIDE-1:0] bits);
    logic [COUNT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < KSTRIDE; i++) begin
      n = n + COUNT_BITS'(bits[i]);
    end
    return n;
  endfunction

endpackage

@@ design/bmw_if.sv @@
interface bmw_pixel_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface bmw_result_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic last_out;

  modport source (output valid, output pixel_out, output last_out, input ready);
  modport sink (input valid, input pixel_out, input last_out, output ready);
endinterface

interface bmw_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bmw_pkg::CFG_INDEX_BITS-1:0] index;
  logic [bmw_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/binary_morphology_window.sv @@
// Channel  Modport  Payload               Transaction when
// pix      sink     pixel_in              pix.valid && pix.ready
// res      source   pixel_out, last_out   res.valid && res.ready
// cfg      sink     index, data           cfg.valid (ready is always high)
//
// One pixel is taken per clock cycle while the queue has room; the rate is set
// by the line store, a single memory read and written once per pixel. A result
// passes from the queue through stages one to three and the output register.
// After reset the line store is cleared, address by address, during which
// pix.ready stays low; configuration writes are taken throughout.
// A stalled result holds the back pipeline, and the four-entry queue lets the
// front keep taking pixels until it fills.
module binary_morphology_window #(
  parameter int MAX_RADIUS = bmw_pkg::DEFAULT_MAX_RADIUS,
  parameter int MAX_WIDTH  = bmw_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  bmw_pixel_if.sink    pix,
  bmw_result_if.source res,
  bmw_cfg_if.sink      cfg
);

  // A queue entry packs the pixel, its result and last flags, and its column.
  localparam int ITEM_W = $clog2(MAX_WIDTH) + 3;

  bmw_pkg::cfg_t regs;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] q_rdata;
  logic              clearing;

  // Configuration registers. The host must write them only between transactions,
  // so every item in flight sees one consistent set; the block does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode         <= bmw_pkg::RESET_MODE;
      regs.radius       <= bmw_pkg::RESET_RADIUS;
      regs.kernel_mask  <= bmw_pkg::RESET_KERNEL;
      regs.frame_width  <= bmw_pkg::RESET_WIDTH;
      regs.frame_height <= bmw_pkg::RESET_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        bmw_pkg::CFG_MODE:   regs.mode         <= cfg.data[bmw_pkg::MODE_BITS-1:0];
        bmw_pkg::CFG_RADIUS: regs.radius       <= cfg.data[bmw_pkg::RADIUS_BITS-1:0];
        bmw_pkg::CFG_KERNEL: regs.kernel_mask  <= cfg.data[bmw_pkg::WINDOW_BITS-1:0];
        bmw_pkg::CFG_WIDTH:  regs.frame_width  <= cfg.data[bmw_pkg::WIDTH_BITS-1:0];
        bmw_pkg::CFG_HEIGHT: regs.frame_height <= cfg.data[bmw_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The front tracks the raster position and decides, per pixel, whether the
  // window that ends there lies inside the frame and whether the pixel is the frame's last.
  bmw_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .regs     (regs),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wdata)
  );

  bmw_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back updates the line store and the window, counts the neighbours
  // under the kernel in two registered steps and holds the result register.
  bmw_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .q_empty  (q_empty),
    .q_item   (q_rdata),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res)
  );

  // No pixel may enter while the line store is still being cleared.
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(pix.valid && pix.ready))
    else $error("pixel transaction during line store clear");

  // The queue must never be written when it is full.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue written while full");

  // No result can exist before the clear pass has finished.
  a_no_result_in_clear : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res.valid)
    else $error("result offered during line store clear");

  // The clear pass starts straight out of reset.
  a_clear_after_reset : assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("line store clear not started after reset");

endmodule

@@ design/bmw_queue.sv @@
module bmw_queue #(
  parameter int DATA_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int DEPTH = bmw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/bmw_front.sv @@
module bmw_front #(
  parameter int MAX_RADIUS = bmw_pkg::DEFAULT_MAX_RADIUS,
  parameter int MAX_WIDTH  = bmw_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  bmw_pixel_if.sink                       pix,
  input  bmw_pkg::cfg_t                   regs,
  input  logic                            clearing,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [$clog2(MAX_WIDTH)+2:0]    q_item
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CMP = (WW > bmw_pkg::WIDTH_BITS) ? WW : bmw_pkg::WIDTH_BITS;
  localparam int HB  = bmw_pkg::HEIGHT_BITS;
  localparam int RB  = bmw_pkg::ROW_BITS;

  logic [CW-1:0] column_count;
  logic [RB-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [RB-1:0] row_count_next;

  logic [CMP-1:0] w_ext;
  logic [WW-1:0]  w;
  logic [HB-1:0]  h;
  logic [WW-1:0]  col_a;
  logic [WW-1:0]  col_n;
  logic [HB-1:0]  row_a;
  logic [HB-1:0]  row_n;
  logic [bmw_pkg::RADIUS_BITS:0] span;
  logic           emit;
  logic           last;
  logic           accept;

  assign pix.ready = !q_full && !clearing;
  assign accept    = pix.valid && pix.ready;
  assign q_push    = accept;
  assign span = {bmw_pkg::eff_radius(regs.radius, MAX_RADIUS), 1'b0};

  always_comb begin
    // Effective frame size: zero reads as one, then saturate.
    w_ext = CMP'(regs.frame_width);
    if (w_ext == '0) begin
      w_ext = CMP'(1);
    end else if (w_ext > CMP'(MAX_WIDTH)) begin
      w_ext = CMP'(MAX_WIDTH);
    end
    w = w_ext[WW-1:0];

    h = regs.frame_height;
    if (h == '0) begin
      h = HB'(1);
    end else if (h > HB'(bmw_pkg::HEIGHT_LIMIT)) begin
      h = HB'(bmw_pkg::HEIGHT_LIMIT);
    end

    // Counters may sit past a bound that was lowered since the last pixel.
    col_a = WW'(column_count);
    row_a = HB'(row_count);
    if (col_a >= w) begin
      col_a = '0;
      row_a = row_a + 1'b1;
    end
    if (row_a >= h) begin
      row_a = '0;
    end

    col_n = col_a + 1'b1;
    row_n = row_a;
    if (col_n >= w) begin
      col_n = '0;
      row_n = row_a + 1'b1;
      if (row_n >= h) begin
        row_n = '0;
      end
    end
    column_count_next = col_n[CW-1:0];
    row_count_next    = row_n[RB-1:0];

    emit = (col_a >= WW'(span)) && (row_a >= HB'(span));
    last = (col_a + 1'b1 == w) && (row_a + 1'b1 == h);
  end

  assign q_item = {pix.pixel_in, emit, last, col_a[CW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

@@ design/bmw_back.sv @@
module bmw_back #(
  parameter int MAX_RADIUS = bmw_pkg::DEFAULT_MAX_RADIUS,
  parameter int MAX_WIDTH  = bmw_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmw_pkg::cfg_t                 regs,
  input  logic                          q_empty,
  input  logic [$clog2(MAX_WIDTH)+2:0]  q_item,
  output logic                          q_pop,
  output logic                          clearing,
  bmw_result_if.source                  res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LB = 2 * MAX_RADIUS;
  localparam int KS = bmw_pkg::KSTRIDE;
  localparam int WB = bmw_pkg::WINDOW_BITS;
  localparam int NB = bmw_pkg::COUNT_BITS;
  localparam int SB = bmw_pkg::SUM_BITS;
  localparam int XB = $clog2(WB);

  logic en;

  // Line store and its read register.
  logic [LB-1:0] line_mem [MAX_WIDTH];
  logic [LB-1:0] rdata;
  logic          clear_busy;
  logic [CW-1:0] clr_addr;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [LB-1:0] mem_wdata;

  // Most recent write, for the back-to-back same-column case.
  logic          lw_valid;
  logic [CW-1:0] lw_addr;
  logic [LB-1:0] lw_data;

  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic          s1_pixel;
  logic          s1_emit;
  logic          s1_last;
  logic [LB-1:0] s1_line;
  logic [LB:0]   s1_vec;

  logic [WB-1:0] window_bits;
  logic          s2_emit;
  logic          s2_last;

  logic [bmw_pkg::RADIUS_BITS-1:0] r;
  logic [WB-1:0] wmask;
  logic [XB-1:0] centre_idx;

  logic          s3_emit;
  logic          s3_last;
  logic          s3_centre;
  logic [NB-1:0] acc_cnt [KS];
  logic [NB-1:0] tot_cnt [KS];
  logic [SB-1:0] accum;
  logic [SB-1:0] total;
  logic          result;

  logic out_valid;
  logic out_pixel;
  logic out_last;

  assign clearing  = clear_busy;
  assign en        = !out_valid || res.ready;
  assign q_pop     = en && !q_empty && !clear_busy;
  assign res.valid     = out_valid;
  assign res.pixel_out = out_pixel;
  assign res.last_out  = out_last;

  assign s1_line   = (lw_valid && lw_addr == s1_col) ? lw_data : rdata;
  assign s1_vec    = {s1_line, s1_pixel};
  assign mem_we    = clear_busy || (en && s1_valid);
  assign mem_waddr = clear_busy ? clr_addr : s1_col;
  assign mem_wdata = clear_busy ? '0 : s1_vec[LB-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rdata <= line_mem[q_item[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == CW'(MAX_WIDTH - 1)) begin
        clear_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_busy) begin
      lw_valid <= 1'b0;
    end else if (en && s1_valid) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      lw_addr <= s1_col;
      lw_data <= s1_vec[LB-1:0];
    end
  end

  // Stage one: item with its line store word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col   <= q_item[CW-1:0];
      s1_last  <= q_item[CW];
      s1_emit  <= q_item[CW+1];
      s1_pixel <= q_item[CW+2];
    end
  end

  // Stage two: the window register holds the state after this item.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      s2_emit     <= 1'b0;
      s2_last     <= 1'b0;
    end else if (en) begin
      if (s1_valid) begin
        window_bits <= {window_bits[WB-KS-1:0], KS'(s1_vec)};
      end
      s2_emit <= s1_valid && s1_emit;
      s2_last <= s1_last;
    end
  end

  assign r          = bmw_pkg::eff_radius(regs.radius, MAX_RADIUS);
  assign wmask      = bmw_pkg::window_mask(regs.kernel_mask, r);
  assign centre_idx = XB'(int'(r) * KS + int'(r));

  // Stage three: per-column counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else if (en) begin
      s3_emit <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last   <= s2_last;
      s3_centre <= window_bits[centre_idx];
      for (int c = 0; c < KS; c++) begin
        acc_cnt[c] <= bmw_pkg::popcount7(window_bits[c*KS +: KS] & wmask[c*KS +: KS]);
        tot_cnt[c] <= bmw_pkg::popcount7(wmask[c*KS +: KS]);
      end
    end
  end

  always_comb begin
    accum = '0;
    total = '0;
    for (int c = 0; c < KS; c++) begin
      accum = accum + SB'(acc_cnt[c]);
      total = total + SB'(tot_cnt[c]);
    end
    case (regs.mode)
      bmw_pkg::MODE_BORDER:   result = s3_centre && (accum < total);
      bmw_pkg::MODE_EXPAND:   result = s3_centre || (accum != '0);
      bmw_pkg::MODE_CONTRACT: result = s3_centre && (accum == total);
      default:                result = 1'b0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel <= result;
      out_last  <= s3_last;
    end
  end

endmodule

@@ dv/binary_morphology_window_tb.sv @@
`timescale 1ns / 100ps

module binary_morphology_window_tb;

  localparam int MAX_R = bmw_pkg::DEFAULT_MAX_RADIUS;
  localparam int MAX_W = bmw_pkg::DEFAULT_MAX_WIDTH;
  localparam int MAX_H = bmw_pkg::HEIGHT_LIMIT;

  // The mode code and the range of index codes that the package does not name.
  localparam logic [bmw_pkg::MODE_BITS-1:0]      MODE_UNUSED      = 2'd3;
  localparam logic [bmw_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [bmw_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_LAST  = 3'd7;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 20;     // comfortably beyond the worst-case result latency
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SIZE_RUN      = 100;
  localparam int RANDOM_ITEMS  = 750;
  localparam int STEADY_ITEMS  = 150;

  // One expected result transaction.
  typedef struct packed {
    logic pixel;
    logic last;
  } mask_bit_t;

  logic clk = 1'b0;
  logic rst;

  bmw_pixel_if  pix_if ();
  bmw_result_if res_if ();
  bmw_cfg_if    cfg_if ();

  binary_morphology_window #(
    .MAX_RADIUS (MAX_R),
    .MAX_WIDTH  (MAX_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .pix (pix_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the configuration registers, starting at their reset values.
  logic [bmw_pkg::MODE_BITS-1:0]   reg_mode   = bmw_pkg::RESET_MODE;
  logic [bmw_pkg::RADIUS_BITS-1:0] reg_radius = bmw_pkg::RESET_RADIUS;
  logic [bmw_pkg::WINDOW_BITS-1:0] reg_kernel = bmw_pkg::RESET_KERNEL;
  logic [bmw_pkg::WIDTH_BITS-1:0]  reg_width  = bmw_pkg::RESET_WIDTH;
  logic [bmw_pkg::HEIGHT_BITS-1:0] reg_height = bmw_pkg::RESET_HEIGHT;

  // Shadow copy of the block's state: the column history per frame column, the
  // 7x7 window (column age c at bits 7c..7c+6) and the raster position.
  logic [5:0]                      line_hist [MAX_W] = '{default: '0};
  logic [bmw_pkg::WINDOW_BITS-1:0] window_hist = '0;
  int unsigned                     col_pos = 0;
  int unsigned                     row_pos = 0;

  mask_bit_t   expected_bits [$];
  int unsigned errors = 0;

  // Idling switches for the two sides, and a request for one long stall.
  bit          sender_idle  = 1'b1;
  bit          sink_idle    = 1'b1;
  int unsigned hold_request = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = (reg_width == 0) ? 1 : reg_width;
    return (w > MAX_W) ? MAX_W : w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = (reg_height == 0) ? 1 : reg_height;
    return (h > MAX_H) ? MAX_H : h;
  endfunction

  // Pixels still to come before the current frame ends, with the counters
  // normalised first in the same way that the block wraps them.
  function automatic int unsigned frame_remainder();
    int unsigned w, h, c, r;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return (h - r) * w - c;
  endfunction

  // Advances the shadow state by one accepted pixel and queues the result that
  // the window centre produces, if the window lies wholly inside the frame.
  function automatic void predict_morphology(input logic p);
    int unsigned r, side, w, h, col, row, total, accum;
    logic [6:0]  column_bits;
    logic        centre;
    mask_bit_t   want;
    r = reg_radius;
    if (r > MAX_R) r = MAX_R;
    side = 2 * r + 1;
    w = eff_width();
    h = eff_height();

    // A register change can leave a counter past its new bound; it wraps here.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;

    column_bits = {line_hist[col % MAX_W], p};
    line_hist[col % MAX_W] = column_bits[5:0];
    window_hist = {window_hist[bmw_pkg::WINDOW_BITS-bmw_pkg::KSTRIDE-1:0], column_bits};

    if (col + 1 >= side && row + 1 >= side) begin
      total = 0;
      accum = 0;
      // Kernel cell (u, v) counts from the top-left, whereas the window holds
      // ages, so the newest pixel sits at the bottom-right of the kernel.
      for (int v = 0; v < side; v++) begin
        for (int u = 0; u < side; u++) begin
          if (!(u == r && v == r) && reg_kernel[v*bmw_pkg::KSTRIDE + u]) begin
            total++;
            accum += window_hist[(side - 1 - u)*bmw_pkg::KSTRIDE + (side - 1 - v)];
          end
        end
      end
      centre = window_hist[r*bmw_pkg::KSTRIDE + r];
      case (reg_mode)
        bmw_pkg::MODE_BORDER:   want.pixel = centre && (accum < total);
        bmw_pkg::MODE_EXPAND:   want.pixel = centre || (accum > 0);
        bmw_pkg::MODE_CONTRACT: want.pixel = centre && (accum == total);
        default:                want.pixel = 1'b0;
      endcase
      want.last = (col + 1 == w) && (row + 1 == h);
      expected_bits.push_back(want);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // Offers one pixel, with an occasional idle burst in front of it, and holds it
  // until the transaction completes. Valid is left high for the next pixel.
  task automatic send_pixel(input logic p);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= p;
    do @(posedge clk); while (!pix_if.ready);
    predict_morphology(p);
  endtask

  // Density is the chance of a set pixel, in percent.
  task automatic send_pixels(input int unsigned count, input int unsigned density);
    repeat (count) send_pixel($urandom_range(0, 99) < density);
  endtask

  // One register write; valid is left high so that writes can follow back to back.
  task automatic write_reg(input logic [bmw_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [bmw_pkg::CFG_DATA_BITS-1:0]  value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      bmw_pkg::CFG_MODE:   reg_mode   = value[bmw_pkg::MODE_BITS-1:0];
      bmw_pkg::CFG_RADIUS: reg_radius = value[bmw_pkg::RADIUS_BITS-1:0];
      bmw_pkg::CFG_KERNEL: reg_kernel = value[bmw_pkg::WINDOW_BITS-1:0];
      bmw_pkg::CFG_WIDTH:  reg_width  = value[bmw_pkg::WIDTH_BITS-1:0];
      bmw_pkg::CFG_HEIGHT: reg_height = value[bmw_pkg::HEIGHT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes all five registers. The unused upper data bits carry random filler,
  // and now and then a write to an unused index goes first; both must be ignored.
  task automatic configure(input logic [bmw_pkg::MODE_BITS-1:0]   mode,
                           input logic [bmw_pkg::RADIUS_BITS-1:0] radius,
                           input logic [bmw_pkg::WINDOW_BITS-1:0] kernel,
                           input logic [bmw_pkg::WIDTH_BITS-1:0]  width,
                           input logic [bmw_pkg::HEIGHT_BITS-1:0] height);
    logic [bmw_pkg::CFG_DATA_BITS-1:0] filler;
    filler = bmw_pkg::CFG_DATA_BITS'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(bmw_pkg::CFG_INDEX_BITS'($urandom_range(CFG_UNUSED_LAST, CFG_UNUSED_FIRST)),
                filler);
    end
    write_reg(bmw_pkg::CFG_MODE,
              {filler[bmw_pkg::CFG_DATA_BITS-1:bmw_pkg::MODE_BITS], mode});
    write_reg(bmw_pkg::CFG_RADIUS,
              {filler[bmw_pkg::CFG_DATA_BITS-1:bmw_pkg::RADIUS_BITS], radius});
    write_reg(bmw_pkg::CFG_KERNEL, kernel);
    write_reg(bmw_pkg::CFG_WIDTH,
              {filler[bmw_pkg::CFG_DATA_BITS-1:bmw_pkg::WIDTH_BITS], width});
    write_reg(bmw_pkg::CFG_HEIGHT,
              {filler[bmw_pkg::CFG_DATA_BITS-1:bmw_pkg::HEIGHT_BITS], height});
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly small frames so that windows fit often; now and then a zero size,
  // a wider frame, the unused mode code or a degenerate kernel.
  task automatic configure_random();
    logic [bmw_pkg::MODE_BITS-1:0]   mode;
    logic [bmw_pkg::RADIUS_BITS-1:0] radius;
    logic [bmw_pkg::WINDOW_BITS-1:0] kernel;
    logic [bmw_pkg::WIDTH_BITS-1:0]  width;
    logic [bmw_pkg::HEIGHT_BITS-1:0] height;
    if ($urandom_range(0, 7) == 0) mode = MODE_UNUSED;
    else mode = bmw_pkg::MODE_BITS'($urandom_range(bmw_pkg::MODE_CONTRACT,
                                                   bmw_pkg::MODE_BORDER));
    radius = bmw_pkg::RADIUS_BITS'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       kernel = '1;
      1:       kernel = '0;
      2:       kernel = bmw_pkg::WINDOW_BITS'(1) << $urandom_range(0, bmw_pkg::WINDOW_BITS - 1);
      default: kernel = bmw_pkg::WINDOW_BITS'({$urandom, $urandom});
    endcase
    if ($urandom_range(0, 9) == 0) width = '0;
    else if ($urandom_range(0, 9) == 0) width = bmw_pkg::WIDTH_BITS'($urandom_range(13, 40));
    else width = bmw_pkg::WIDTH_BITS'($urandom_range(1, 12));
    if ($urandom_range(0, 9) == 0) height = '0;
    else height = bmw_pkg::HEIGHT_BITS'($urandom_range(1, 10));
    configure(mode, radius, kernel, width, height);
  endtask

  // Stops offering pixels, waits for every outstanding result (with a limit),
  // then lets the pipeline run empty of pixels that produce no result.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    pix_if.valid <= 1'b0;
    while (expected_bits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bits.size() != 0) begin
      $error("%0d expected result transactions never arrived", expected_bits.size());
      errors++;
      expected_bits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values: a wide frame with radius one, so a handful of pixels must
  // produce nothing. The first pixel also waits out the line-store clearing pass.
  task automatic test_reset_values();
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    wait_idle();
  endtask

  // Radius zero with zero width and height, which act as a one-pixel frame:
  // every pixel is its own frame and carries last_out. Border gives zero, expand
  // and contract copy the centre, and the unused mode code gives zero. The
  // counters are left mid-row by the previous test, so they must wrap at once.
  task automatic test_single_pixel_frames();
    logic [bmw_pkg::MODE_BITS-1:0] modes [4] = '{bmw_pkg::MODE_BORDER,
                                                 bmw_pkg::MODE_EXPAND,
                                                 bmw_pkg::MODE_CONTRACT,
                                                 MODE_UNUSED};
    for (int i = 0; i < 4; i++) begin
      configure(modes[i], '0, (i % 2 == 0) ? '1 : '0, '0, '0);
      send_pixel(1'b0);
      send_pixel(1'b1);
      wait_idle();
    end
  endtask

  // A 3x3 frame of set pixels under a full kernel: exactly one window, which
  // contracts to a set bit and ends the frame.
  task automatic test_full_window();
    configure(bmw_pkg::MODE_CONTRACT, 2'd1, '1, 11'd3, 13'd3);
    send_pixels(9, 100);
    wait_idle();
  endtask

  // A frame narrower than the largest window yields no result at all.
  task automatic test_tiny_frame();
    configure(bmw_pkg::MODE_EXPAND, 2'd3, '1, 11'd2, 13'd1);
    send_pixels(2, 100);
    wait_idle();
  endtask

  // Register values beyond the block's limits: every width bit set saturates to
  // the line-store width, and every height bit set saturates to the row limit.
  // Radius zero gives a result per pixel. Only a stretch of each frame is sent,
  // so the registers that follow are changed in the middle of a frame.
  task automatic test_size_limits();
    configure(bmw_pkg::MODE_CONTRACT, '0, '1, '1, 13'd1);
    send_pixels(SIZE_RUN, 50);
    wait_idle();
    configure(bmw_pkg::MODE_EXPAND, '0, '0, 11'd1, '1);
    send_pixels(SIZE_RUN, 50);
    wait_idle();
  endtask

  // Random phases. Most finish the frame in progress and may add another whole
  // frame; the rest send a short broken run, so that the next phase changes the
  // registers in the middle of a frame.
  task automatic test_random_frames(input int unsigned target);
    int unsigned sent, count, density;
    sent = 0;
    while (sent < target) begin
      configure_random();
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 50;
        2:       density = 85;
        default: density = 100;
      endcase
      if ($urandom_range(0, 4) != 0) begin
        count = frame_remainder() + eff_width() * eff_height() * $urandom_range(0, 1);
      end else begin
        count = $urandom_range(1, 30);
      end
      send_pixels(count, density);
      sent += count;
      wait_idle();
    end
  endtask

  // The receiver stops for a long stretch while pixels keep coming, so the
  // item queue fills and the block must hold off its input.
  task automatic test_backpressure();
    configure(bmw_pkg::MODE_EXPAND, 2'd1, '1, 11'd8, 13'd8);
    hold_request = HOLD_CYCLES;
    send_pixels(frame_remainder() + 64, 50);
    wait_idle();
  endtask

  // Back-to-back transactions on both sides for the closing stretch.
  task automatic test_steady_stream();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    test_random_frames(STEADY_ITEMS);
  endtask

  // Result receiver. A long hold, when requested, is counted here; otherwise
  // ready drops in random bursts while idling is enabled.
  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        res_if.ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Every result transaction is compared with the oldest expectation. Sampling
  // happens straight after the edge, so the values seen are those at the edge.
  always @(posedge clk) begin : result_check
    mask_bit_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_bits.size() == 0) begin
        $error("result transaction with nothing expected: pixel_out %0b, last_out %0b",
               res_if.pixel_out, res_if.last_out);
        errors++;
      end else begin
        want = expected_bits.pop_front();
        if (res_if.pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0b, actual %0b", want.pixel, res_if.pixel_out);
          errors++;
        end
        if (res_if.last_out !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, res_if.last_out);
          errors++;
        end
      end
    end
  end

  initial begin : sequencer
    rst             <= 1'b1;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= bmw_pkg::CFG_MODE;
    cfg_if.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_single_pixel_frames();
    test_full_window();
    test_tiny_frame();
    test_size_limits();
    test_random_frames(RANDOM_ITEMS);
    test_backpressure();
    test_steady_stream();

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Time limit: several times the slowest correct run, clearing pass and long hold included.
  initial begin : watchdog
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/bmw_pkg.sv
design/bmw_if.sv
design/bmw_queue.sv
design/bmw_front.sv
design/bmw_back.sv
design/binary_morphology_window.sv
dv/binary_morphology_window_tb.sv
